/* rtl/core/circular_linked_list_manager_assert.svh */
// ---------------------------------------------------------------------------
// Circular linked list manager assertion macros
// Shared property forms for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_LINKED_LIST_MANAGER_ASSERT_SVH
`define CIRCULAR_LINKED_LIST_MANAGER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define CLLM_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define CLLM_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/cllm_pkg.sv */
// ---------------------------------------------------------------------------
// Circular linked list manager package
// Command codes, microcode word layout and the microprogram ROM.
// ---------------------------------------------------------------------------
package cllm_pkg;

  localparam int unsigned NODE_W         = 6;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned NODE_COUNT_DEF = 64;
  localparam int unsigned UADDR_W        = 5;

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_SWAP   = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_PREV   = 3'd5
  } cmd_e;

  // operand / data sources of the datapath
  typedef enum logic [2:0] {
    SRC_A,
    SRC_B,
    SRC_T0,
    SRC_T1,
    SRC_RF,
    SRC_RB
  } src_e;

  typedef enum logic [1:0] {
    COND_NONE,
    COND_RF_EQ_A,
    COND_RF_EQ_B
  } cond_e;

  // microprogram addresses
  typedef enum logic [UADDR_W-1:0] {
    UA_NOP,
    UA_INIT,
    UA_NEXT0, UA_NEXT1,
    UA_PREV0, UA_PREV1,
    UA_REM0,  UA_REM1,
    UA_ADD0,  UA_ADD1, UA_ADD2, UA_ADD3,
    UA_SW0,   UA_SW1,  UA_SW2,
    UA_D0,    UA_D1,   UA_D2,   UA_D3,   UA_D4,
    UA_ADJ0,  UA_ADJ1, UA_ADJ2, UA_ADJ3, UA_ADJ4
  } ua_e;

  typedef struct packed {
    logic  rf_en;    // read forward link
    src_e  rf_sel;
    logic  rb_en;    // read backward link
    src_e  rb_sel;
    logic  wf_en;    // write forward link
    src_e  wf_asel;
    src_e  wf_dsel;
    logic  wb_en;    // write backward link
    src_e  wb_asel;
    src_e  wb_dsel;
    logic  cap_en;   // RF -> T0, RB -> T1
    logic  res_en;
    src_e  res_sel;
    cond_e cond;
    logic  xchg;     // exchange A and B when the jump is taken
    ua_e   target;
    logic  last;
  } ucw_t;

  typedef struct packed {
    logic step;      // microstep executes this cycle
    logic load;      // operands taken from the input transfer
    logic swap_ab;
    ucw_t uw;
  } dp_ctl_t;

  typedef struct packed {
    logic rf_eq_a;
    logic rf_eq_b;
  } dp_stat_t;

  // Microprogram. Reads (RF, RB) are registered and see a write to the same
  // link in the same step. Writes within one step go to different link arrays
  // only.
  function automatic ucw_t cllm_ucode(input ua_e addr);
    ucw_t cw;
    cw = '0;
    case (addr)
      UA_NOP: begin
        cw.last = 1'b1;
      end
      UA_INIT: begin
        cw.wf_en = 1'b1; cw.wf_asel = SRC_A; cw.wf_dsel = SRC_A;
        cw.wb_en = 1'b1; cw.wb_asel = SRC_A; cw.wb_dsel = SRC_A;
        cw.last  = 1'b1;
      end
      UA_NEXT0: begin
        cw.rf_en = 1'b1; cw.rf_sel = SRC_A;
      end
      UA_NEXT1: begin
        cw.res_en = 1'b1; cw.res_sel = SRC_RF; cw.last = 1'b1;
      end
      UA_PREV0: begin
        cw.rb_en = 1'b1; cw.rb_sel = SRC_A;
      end
      UA_PREV1: begin
        cw.res_en = 1'b1; cw.res_sel = SRC_RB; cw.last = 1'b1;
      end
      UA_REM0: begin
        cw.rf_en = 1'b1; cw.rf_sel = SRC_A;
        cw.rb_en = 1'b1; cw.rb_sel = SRC_A;
      end
      UA_REM1: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_RF; cw.wb_dsel = SRC_RB;
        cw.wf_en = 1'b1; cw.wf_asel = SRC_RB; cw.wf_dsel = SRC_RF;
        cw.last  = 1'b1;
      end
      UA_ADD0: begin
        cw.rf_en = 1'b1; cw.rf_sel = SRC_A;
      end
      UA_ADD1: begin
        cw.wf_en = 1'b1; cw.wf_asel = SRC_B; cw.wf_dsel = SRC_RF;
        cw.wb_en = 1'b1; cw.wb_asel = SRC_B; cw.wb_dsel = SRC_A;
      end
      UA_ADD2: begin
        cw.wf_en = 1'b1; cw.wf_asel = SRC_A; cw.wf_dsel = SRC_B;
        cw.rf_en = 1'b1; cw.rf_sel  = SRC_B;
      end
      UA_ADD3: begin
        cw.wb_en  = 1'b1; cw.wb_asel = SRC_RF; cw.wb_dsel = SRC_B;
        cw.res_en = 1'b1; cw.res_sel = SRC_B;
        cw.last   = 1'b1;
      end
      UA_SW0: begin
        cw.rf_en = 1'b1; cw.rf_sel = SRC_A;
        cw.rb_en = 1'b1; cw.rb_sel = SRC_A;
      end
      UA_SW1: begin
        cw.rf_en  = 1'b1; cw.rf_sel = SRC_B;
        cw.cap_en = 1'b1;
        cw.cond   = COND_RF_EQ_B; cw.target = UA_ADJ1;
      end
      UA_SW2: begin
        cw.cond = COND_RF_EQ_A; cw.xchg = 1'b1; cw.target = UA_ADJ0;
      end
      UA_D0: begin
        cw.wf_en = 1'b1; cw.wf_asel = SRC_T1; cw.wf_dsel = SRC_B;
        cw.wb_en = 1'b1; cw.wb_asel = SRC_T0; cw.wb_dsel = SRC_B;
        cw.rb_en = 1'b1; cw.rb_sel  = SRC_B;
      end
      UA_D1: begin
        cw.wf_en = 1'b1; cw.wf_asel = SRC_RB; cw.wf_dsel = SRC_A;
        cw.rf_en = 1'b1; cw.rf_sel  = SRC_B;
      end
      UA_D2: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_RF; cw.wb_dsel = SRC_A;
        cw.wf_en = 1'b1; cw.wf_asel = SRC_A;  cw.wf_dsel = SRC_RF;
        cw.rb_en = 1'b1; cw.rb_sel  = SRC_B;
      end
      UA_D3: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_A; cw.wb_dsel = SRC_RB;
        cw.wf_en = 1'b1; cw.wf_asel = SRC_B; cw.wf_dsel = SRC_T0;
      end
      UA_D4: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_B; cw.wb_dsel = SRC_T1;
        cw.last  = 1'b1;
      end
      UA_ADJ0: begin
        cw.rb_en = 1'b1; cw.rb_sel = SRC_A;
      end
      UA_ADJ1: begin
        cw.wf_en = 1'b1; cw.wf_asel = SRC_RB; cw.wf_dsel = SRC_B;
        cw.rf_en = 1'b1; cw.rf_sel  = SRC_B;
      end
      UA_ADJ2: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_RF; cw.wb_dsel = SRC_A;
        cw.rb_en = 1'b1; cw.rb_sel  = SRC_A;
      end
      UA_ADJ3: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_B; cw.wb_dsel = SRC_RB;
        cw.wf_en = 1'b1; cw.wf_asel = SRC_A; cw.wf_dsel = SRC_RF;
      end
      UA_ADJ4: begin
        cw.wb_en = 1'b1; cw.wb_asel = SRC_A; cw.wb_dsel = SRC_B;
        cw.wf_en = 1'b1; cw.wf_asel = SRC_B; cw.wf_dsel = SRC_A;
        cw.last  = 1'b1;
      end
      default: begin
        cw.last = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

/* rtl/core/cllm_link_ram.sv */
// ---------------------------------------------------------------------------
// Link memory
// One write and one read port, registered read with write-through, per-entry
// valid bits so an unwritten entry reads as its own index.
// ---------------------------------------------------------------------------
module cllm_link_ram #(
  parameter  int unsigned DEPTH  = cllm_pkg::NODE_COUNT_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  cllm_pkg::node_t     wdata_i,
  input  logic                re_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output cllm_pkg::node_t     rdata_o
);

  cllm_pkg::node_t mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  cllm_pkg::node_t  rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-through on a same-cycle hit
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else if (vld_q[raddr_i]) begin
        rdata_q <= mem[raddr_i];
      end else begin
        rdata_q <= cllm_pkg::NODE_W'(raddr_i);
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cllm_datapath.sv */
// ---------------------------------------------------------------------------
// Link datapath
// Operand and temp registers, source muxes and the two link memories,
// driven one control word per cycle.
// ---------------------------------------------------------------------------
module cllm_datapath #(
  parameter int unsigned NODE_COUNT = cllm_pkg::NODE_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cllm_pkg::dp_ctl_t   ctl_i,
  input  cllm_pkg::node_t     node_a_i,
  input  cllm_pkg::node_t     node_b_i,
  output cllm_pkg::dp_stat_t  stat_o,
  output cllm_pkg::node_t     res_o
);

  // node fields are NODE_W wide, so no more than 2**NODE_W entries are reachable
  localparam int unsigned LINK_DEPTH = (NODE_COUNT < (2 ** cllm_pkg::NODE_W)) ?
                                       NODE_COUNT : (2 ** cllm_pkg::NODE_W);
  localparam int unsigned ADDR_W     = $clog2(LINK_DEPTH);

  cllm_pkg::node_t a_q, b_q, t0_q, t1_q, res_q;
  cllm_pkg::node_t rf_data, rb_data;
  cllm_pkg::node_t rf_addr, rb_addr, wf_addr, wf_data, wb_addr, wb_data, res_src;
  logic            rf_re, rb_re, wf_we, wb_we;

  function automatic cllm_pkg::node_t pick(
    input cllm_pkg::src_e  sel,
    input cllm_pkg::node_t a,
    input cllm_pkg::node_t b,
    input cllm_pkg::node_t t0,
    input cllm_pkg::node_t t1,
    input cllm_pkg::node_t rf,
    input cllm_pkg::node_t rb
  );
    cllm_pkg::node_t v;
    case (sel)
      cllm_pkg::SRC_A:  v = a;
      cllm_pkg::SRC_B:  v = b;
      cllm_pkg::SRC_T0: v = t0;
      cllm_pkg::SRC_T1: v = t1;
      cllm_pkg::SRC_RF: v = rf;
      cllm_pkg::SRC_RB: v = rb;
      default:          v = a;
    endcase
    return v;
  endfunction

  always_comb begin
    rf_addr = pick(ctl_i.uw.rf_sel,  a_q, b_q, t0_q, t1_q, rf_data, rb_data);
    rb_addr = pick(ctl_i.uw.rb_sel,  a_q, b_q, t0_q, t1_q, rf_data, rb_data);
    wf_addr = pick(ctl_i.uw.wf_asel, a_q, b_q, t0_q, t1_q, rf_data, rb_data);
    wf_data = pick(ctl_i.uw.wf_dsel, a_q, b_q, t0_q, t1_q, rf_data, rb_data);
    wb_addr = pick(ctl_i.uw.wb_asel, a_q, b_q, t0_q, t1_q, rf_data, rb_data);
    wb_data = pick(ctl_i.uw.wb_dsel, a_q, b_q, t0_q, t1_q, rf_data, rb_data);
    res_src = pick(ctl_i.uw.res_sel, a_q, b_q, t0_q, t1_q, rf_data, rb_data);
  end

  assign rf_re = ctl_i.step && ctl_i.uw.rf_en;
  assign rb_re = ctl_i.step && ctl_i.uw.rb_en;
  assign wf_we = ctl_i.step && ctl_i.uw.wf_en;
  assign wb_we = ctl_i.step && ctl_i.uw.wb_en;

  cllm_link_ram #(
    .DEPTH (LINK_DEPTH)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wf_we),
    .waddr_i (wf_addr[ADDR_W-1:0]),
    .wdata_i (wf_data),
    .re_i    (rf_re),
    .raddr_i (rf_addr[ADDR_W-1:0]),
    .rdata_o (rf_data)
  );

  cllm_link_ram #(
    .DEPTH (LINK_DEPTH)
  ) u_bwd_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (wb_we),
    .waddr_i (wb_addr[ADDR_W-1:0]),
    .wdata_i (wb_data),
    .re_i    (rb_re),
    .raddr_i (rb_addr[ADDR_W-1:0]),
    .rdata_o (rb_data)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q   <= node_a_i;
      b_q   <= node_b_i;
      res_q <= node_a_i;
    end else if (ctl_i.step) begin
      if (ctl_i.swap_ab) begin
        a_q <= b_q;
        b_q <= a_q;
      end
      if (ctl_i.uw.cap_en) begin
        t0_q <= rf_data;
        t1_q <= rb_data;
      end
      if (ctl_i.uw.res_en) begin
        res_q <= res_src;
      end
    end
  end

  assign stat_o.rf_eq_a = (rf_data == a_q);
  assign stat_o.rf_eq_b = (rf_data == b_q);
  assign res_o = (ctl_i.step && ctl_i.uw.res_en) ? res_src : res_q;

endmodule

/* rtl/core/cllm_seq.sv */
// ---------------------------------------------------------------------------
// Microcode sequencer
// Command dispatch, step counter with conditional jumps, result register.
// ---------------------------------------------------------------------------
module cllm_seq #(
  parameter int unsigned NODE_COUNT = cllm_pkg::NODE_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [cllm_pkg::CMD_W-1:0]   cmd_i,
  input  cllm_pkg::node_t              node_a_i,
  input  cllm_pkg::node_t              node_b_i,
  input  cllm_pkg::dp_stat_t           stat_i,
  input  cllm_pkg::node_t              res_i,
  output cllm_pkg::dp_ctl_t            ctl_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cllm_pkg::node_t              out_node_o,
  output logic                         out_has_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } st_e;

  st_e             state_q;
  cllm_pkg::ua_e   upc_q;
  logic            has_q;
  logic            out_valid_q;
  cllm_pkg::node_t out_node_q;
  logic            out_has_q;

  cllm_pkg::ucw_t  uw;
  cllm_pkg::ua_e   entry;
  logic            has_d;
  logic            a_ok, b_ok;
  logic            accept, step, taken, out_free;

  assign uw       = cllm_pkg::cllm_ucode(upc_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign step     = (state_q == ST_RUN) && (!uw.last || out_free);
  assign taken    = ((uw.cond == cllm_pkg::COND_RF_EQ_A) && stat_i.rf_eq_a) ||
                    ((uw.cond == cllm_pkg::COND_RF_EQ_B) && stat_i.rf_eq_b);
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign a_ok = int'(node_a_i) < NODE_COUNT;
  assign b_ok = int'(node_b_i) < NODE_COUNT;

  // command dispatch; rejected commands run the empty program
  always_comb begin
    entry = cllm_pkg::UA_NOP;
    has_d = 1'b0;
    case (cllm_pkg::cmd_e'(cmd_i))
      cllm_pkg::CMD_INIT: begin
        if (a_ok) entry = cllm_pkg::UA_INIT;
      end
      cllm_pkg::CMD_ADD: begin
        if (a_ok && b_ok) begin
          entry = cllm_pkg::UA_ADD0;
          has_d = 1'b1;
        end
      end
      cllm_pkg::CMD_REMOVE: begin
        if (a_ok) begin
          entry = cllm_pkg::UA_REM0;
          has_d = 1'b1;
        end
      end
      cllm_pkg::CMD_SWAP: begin
        if (a_ok && b_ok && (node_a_i != node_b_i)) entry = cllm_pkg::UA_SW0;
      end
      cllm_pkg::CMD_NEXT: begin
        if (a_ok) begin
          entry = cllm_pkg::UA_NEXT0;
          has_d = 1'b1;
        end
      end
      cllm_pkg::CMD_PREV: begin
        if (a_ok) begin
          entry = cllm_pkg::UA_PREV0;
          has_d = 1'b1;
        end
      end
      default: begin
        entry = cllm_pkg::UA_NOP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      upc_q       <= cllm_pkg::UA_NOP;
      has_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_node_q  <= '0;
      out_has_q   <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= ST_RUN;
        upc_q   <= entry;
        has_q   <= has_d;
      end else if (step) begin
        if (uw.last) begin
          state_q <= ST_IDLE;
        end else if (taken) begin
          upc_q <= uw.target;
        end else begin
          upc_q <= cllm_pkg::ua_e'(upc_q + 1'b1);
        end
      end
      if (step && uw.last) begin
        out_valid_q <= 1'b1;
        out_node_q  <= res_i;
        out_has_q   <= has_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign ctl_o.step    = step;
  assign ctl_o.load    = accept;
  assign ctl_o.swap_ab = step && taken && uw.xchg;
  assign ctl_o.uw      = uw;

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign out_has_o   = out_has_q;

endmodule

/* rtl/core/circular_linked_list_manager.sv */
// ---------------------------------------------------------------------------
// Circular linked list manager
// Keeps forward and backward links for a pool of nodes and runs one list
// command per input transfer: init, add after, remove, swap, read next and
// read prev. Every transfer in gives exactly one transfer out, in order.
// The input transfer is taken, then the command runs as a short microprogram
// from a ROM, one step per cycle while no final step stalls, against two link
// memories (forward and backward), each with one read and one write port.
// Steps per command: rejected or no-op 1, init 1, next/prev/remove 2, add 4,
// swap of neighbors in list order 6, swap of distant nodes 8. Each item holds
// the block from its accept through its final step; the swap programs, bound
// by one link read per array per step, set the worst case. After reset all
// nodes link to themselves at once (valid bit per entry), so there is no
// initialization sweep. A finished result sits in an output register; the
// next command is accepted while it waits, and only its final step stalls
// until that register frees.
// ---------------------------------------------------------------------------
`include "circular_linked_list_manager_assert.svh"

module circular_linked_list_manager #(
  parameter int unsigned NODE_COUNT = cllm_pkg::NODE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: command transfers
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [2:0] cmd, [8:3] node_a, [14:9] node_b, [15] zero
  // master side: result transfers
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [5:0] result_node, [7:6] zero
  output logic        m_axis_tuser    // [0] has_result
);

  logic [cllm_pkg::CMD_W-1:0] cmd;
  cllm_pkg::node_t            node_a, node_b;
  cllm_pkg::dp_ctl_t          dp_ctl;
  cllm_pkg::dp_stat_t         dp_stat;
  cllm_pkg::node_t            dp_res;
  cllm_pkg::node_t            out_node;

  // unpack the command transfer
  assign cmd    = s_axis_tdata[2:0];
  assign node_a = s_axis_tdata[8:3];
  assign node_b = s_axis_tdata[14:9];

  // sequencer: dispatch, step counter, result register
  cllm_seq #(
    .NODE_COUNT (NODE_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (cmd),
    .node_a_i    (node_a),
    .node_b_i    (node_b),
    .stat_i      (dp_stat),
    .res_i       (dp_res),
    .ctl_o       (dp_ctl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_node_o  (out_node),
    .out_has_o   (m_axis_tuser)
  );

  // datapath: operand/temp registers and the link memories
  cllm_datapath #(
    .NODE_COUNT (NODE_COUNT)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (dp_ctl),
    .node_a_i (node_a),
    .node_b_i (node_b),
    .stat_o   (dp_stat),
    .res_o    (dp_res)
  );

  assign m_axis_tdata = {2'b00, out_node};

  // a command in flight blocks the next one
  `CLLM_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while a command runs")
  // no microstep while idle
  `CLLM_ASSERT_SAME(a_no_step_idle, s_axis_tready, !dp_ctl.step, "microstep while idle")
  // the final step only runs with room in the output register
  `CLLM_ASSERT_SAME(a_last_has_room, dp_ctl.step && dp_ctl.uw.last, !m_axis_tvalid || m_axis_tready, "pending result overwritten")
  // the final step always posts a result
  `CLLM_ASSERT_NEXT(a_result_after_last, dp_ctl.step && dp_ctl.uw.last, m_axis_tvalid, "final step without result")

endmodule
